[hw/rtl/smpe_pkg.sv]
// Package for the serial mouse port emulation core.
// Beat types, command and port codes, shared constants and the FIFO cell control word.
// No dependencies.
package smpe_pkg;

  parameter int unsigned FIFO_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [2:0] PORT_DATA   = 3'd0;
  localparam logic [2:0] PORT_MODE   = 3'd4;
  localparam logic [2:0] PORT_STATUS = 3'd5;

  localparam logic [7:0] ID_BYTE     = 8'h4D;
  localparam int unsigned ID_COUNT   = 6;
  localparam logic [7:0] PKT_BASE    = 8'h40;
  localparam logic [7:0] STATUS_BYTE = 8'h01;
  localparam int unsigned PKT_LEN    = 3;

  typedef struct packed {
    cmd_e              command;
    logic [2:0]        port;
    logic [7:0]        write_data;
    logic [1:0]        buttons;
    logic signed [7:0] x_move;
    logic signed [7:0] y_move;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
  } out_beat_t;

  // control broadcast to every FIFO cell
  typedef struct packed {
    logic       pop;
    logic       load_id;
    logic       push;
    logic [7:0] pkt0;
    logic [7:0] pkt1;
    logic [7:0] pkt2;
  } cell_ctrl_t;

endpackage

[hw/rtl/smpe_fifo_cell.sv]
// One entry of the shifting receive FIFO.
// Takes its neighbor's byte on a pop, an ID byte on a mode toggle, a packet byte on a push.
// Depends on smpe_pkg.
module smpe_fifo_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smpe_pkg::cell_ctrl_t  ctrl_i,
  input  logic [CW-1:0]         count_i,
  input  logic [7:0]            next_i,
  output logic [7:0]            data_o
);

  localparam logic [CW-1:0] Idx = CW'(INDEX);

  logic [7:0]    data_q, data_d;
  logic [CW-1:0] offset;

  assign offset = Idx - count_i;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.pop) begin
      data_d = next_i;
    end else if (ctrl_i.load_id) begin
      if (INDEX < smpe_pkg::ID_COUNT) data_d = smpe_pkg::ID_BYTE;
    end else if (ctrl_i.push && (count_i <= Idx)) begin
      case (offset)
        CW'(0):  data_d = ctrl_i.pkt0;
        CW'(1):  data_d = ctrl_i.pkt1;
        CW'(2):  data_d = ctrl_i.pkt2;
        default: data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

[hw/rtl/smpe_out_buf.sv]
// Two-entry result buffer between the core and the output channel.
// Stalls the input only when both entries hold undelivered beats.
// Depends on smpe_pkg.
module smpe_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  smpe_pkg::out_beat_t  beat_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output smpe_pkg::out_beat_t  out_beat_o
);

  logic                v0_q, v1_q;
  smpe_pkg::out_beat_t s0_q, s1_q;
  logic                pop;

  assign pop = v0_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (pop) begin
        if (v1_q) begin
          v0_q <= 1'b1;
          v1_q <= push_i;
        end else begin
          v0_q <= push_i;
        end
      end else if (push_i) begin
        if (v0_q) v1_q <= 1'b1;
        else      v0_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (v1_q) begin
        s0_q <= s1_q;
        if (push_i) s1_q <= beat_i;
      end else if (push_i) begin
        s0_q <= beat_i;
      end
    end else if (push_i) begin
      if (v0_q) s1_q <= beat_i;
      else      s0_q <= beat_i;
    end
  end

  assign full_o      = v1_q;
  assign out_valid_o = v0_q;
  assign out_beat_o  = s0_q;

endmodule

[hw/rtl/serial_mouse_port_emulation_core.sv]
// Serial mouse port emulation core: port registers, shifting receive FIFO, result buffer.
// Depends on smpe_pkg, smpe_fifo_cell, smpe_out_buf.
//
//   channel | signals                           | beat type
//   in      | in_valid_i, in_stall_o, in_beat_i | smpe_pkg::in_beat_t
//   out     | out_valid_o, out_stall_i, out_beat_o | smpe_pkg::out_beat_t
//
// One item per cycle while in_stall_o is low; its result is queued in the result buffer.
// All state updates in the accepting cycle, so the next item sees them.
// Reset clears the port registers, every FIFO cell and the fill count.
// in_stall_o rises only when two results are waiting in the output buffer.
module serial_mouse_port_emulation_core #(
  parameter int unsigned FIFO_DEPTH = smpe_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smpe_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smpe_pkg::out_beat_t out_beat_o
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic [7:0]          regs_q [8];
  logic [7:0]          fifo_data [FIFO_DEPTH];
  logic [CW-1:0]       count_q, count_d;
  logic                acc, toggle, pop, evt, full;
  logic [7:0]          old_reg;
  logic [CW:0]         count_ext;
  smpe_pkg::cell_ctrl_t ctrl;
  smpe_pkg::out_beat_t res;

  assign acc     = in_valid_i && !in_stall_o;
  assign old_reg = regs_q[in_beat_i.port];
  assign toggle  = acc && (in_beat_i.command == smpe_pkg::CMD_WRITE)
                   && (in_beat_i.port == smpe_pkg::PORT_MODE)
                   && (in_beat_i.write_data[0] ^ old_reg[0]);
  assign pop     = acc && (in_beat_i.command == smpe_pkg::CMD_READ)
                   && (in_beat_i.port == smpe_pkg::PORT_DATA);
  assign evt     = acc && (in_beat_i.command == smpe_pkg::CMD_EVENT);

  always_comb begin
    ctrl.pop     = pop;
    ctrl.load_id = toggle;
    ctrl.push    = evt;
    ctrl.pkt0    = smpe_pkg::PKT_BASE | {2'b00, in_beat_i.buttons, 4'b0000}
                   | {4'b0000, {2{in_beat_i.y_move[7]}}, {2{in_beat_i.x_move[7]}}};
    ctrl.pkt1    = {2'b00, in_beat_i.x_move[5:0]};
    ctrl.pkt2    = {2'b00, in_beat_i.y_move[5:0]};
  end

  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic [7:0] nxt;
    if (i == FIFO_DEPTH - 1) begin : g_last
      assign nxt = fifo_data[i];
    end else begin : g_mid
      assign nxt = fifo_data[i+1];
    end
    smpe_fifo_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .next_i  (nxt),
      .data_o  (fifo_data[i])
    );
  end

  assign count_ext = {1'b0, count_q} + (CW+1)'(smpe_pkg::PKT_LEN);

  always_comb begin
    count_d = count_q;
    if (toggle) begin
      count_d = CW'(smpe_pkg::ID_COUNT);
    end else if (evt) begin
      count_d = (count_ext > (CW+1)'(FIFO_DEPTH)) ? CW'(FIFO_DEPTH) : count_ext[CW-1:0];
    end else if (pop && (count_q != '0)) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    res.read_data   = '0;
    res.irq_request = 1'b0;
    unique case (in_beat_i.command)
      smpe_pkg::CMD_WRITE: res.irq_request = toggle;
      smpe_pkg::CMD_READ: begin
        if (in_beat_i.port == smpe_pkg::PORT_DATA) begin
          res.read_data   = fifo_data[0];
          res.irq_request = count_q > CW'(1);
        end else if (in_beat_i.port == smpe_pkg::PORT_STATUS) begin
          res.read_data = smpe_pkg::STATUS_BYTE;
        end else begin
          res.read_data = old_reg;
        end
      end
      smpe_pkg::CMD_EVENT: res.irq_request = (count_q == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < 8; k++) regs_q[k] <= '0;
    end else begin
      count_q <= count_d;
      if (acc && (in_beat_i.command == smpe_pkg::CMD_WRITE)) begin
        regs_q[in_beat_i.port] <= in_beat_i.write_data;
      end else if (pop) begin
        regs_q[smpe_pkg::PORT_MODE] <= {7'b0000000, ~regs_q[smpe_pkg::PORT_MODE][0]};
      end
    end
  end

  smpe_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (acc),
    .beat_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  assign in_stall_o = full;

endmodule

[hw/rtl/smpe_checker.sv]
// Port-level checks for the serial mouse port emulation core, bound to the top level.
// Depends on smpe_pkg and serial_mouse_port_emulation_core.
module smpe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input smpe_pkg::in_beat_t  in_beat_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input smpe_pkg::out_beat_t out_beat_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o
    && in_beat_i.command == smpe_pkg::CMD_READ && in_beat_i.port == smpe_pkg::PORT_STATUS
    |=> out_valid_o && out_beat_o.read_data == smpe_pkg::STATUS_BYTE
        && !out_beat_o.irq_request)
    else $error("status port read wrong");

  a_event_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o && in_beat_i.command == smpe_pkg::CMD_EVENT
    |=> out_valid_o && out_beat_o.read_data == 8'h00)
    else $error("event returned read data");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("stall raised while result drained");

endmodule

bind serial_mouse_port_emulation_core smpe_checker u_smpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
